// File: hw/rtl/lottery_ticket_sum_heap_defines.svh
// ----------------------------------------------------------------------------
// Lottery ticket sum heap - assertion macros
// Clocked, reset-qualified property wrappers shared by the heap RTL.
// ----------------------------------------------------------------------------
`ifndef LOTTERY_TICKET_SUM_HEAP_DEFINES_SVH
`define LOTTERY_TICKET_SUM_HEAP_DEFINES_SVH

// same-cycle implication
`define LTHS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LTHS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/lths_pkg.sv
// ----------------------------------------------------------------------------
// Lottery ticket sum heap - package
// Field widths, defaults and operation and status codes.
// ----------------------------------------------------------------------------
package lths_pkg;

   localparam int ID_W            = 6;
   localparam int ID_COUNT        = 64;
   localparam int TICKET_IN_W     = 16;
   localparam int SUM_W           = 22;
   localparam int COUNT_OUT_W     = 7;
   localparam int STATUS_W        = 2;
   localparam int MAX_THREADS_DEF = 64;
   localparam int TICKET_BITS_DEF = 16;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_ABSENT = 2'd2
   } status_type;

endpackage

// File: hw/rtl/lths_alu.sv
// ----------------------------------------------------------------------------
// Lottery ticket sum heap - shared arithmetic unit
// One three-operand sum (a + b - c, modulo the sum width) and one ticket
// magnitude compare, time-shared by the steps of the sequencer.
// ----------------------------------------------------------------------------
module lths_alu #(
   parameter int TICKET_BITS = lths_pkg::TICKET_BITS_DEF
) (
   input  logic [lths_pkg::SUM_W-1:0] add_a,
   input  logic [lths_pkg::SUM_W-1:0] add_b,
   input  logic [lths_pkg::SUM_W-1:0] add_c,
   input  logic [TICKET_BITS-1:0]     cmp_x,
   input  logic [TICKET_BITS-1:0]     cmp_y,
   output logic [lths_pkg::SUM_W-1:0] sum,
   output logic                       gt
);
   import lths_pkg::*;

   assign sum = add_a + add_b - add_c;
   assign gt  = cmp_x > cmp_y;

endmodule

// File: hw/rtl/lottery_ticket_sum_heap.sv
// Each heap level costs a read and a write of the slot memory, which has one read
// port, one write port and registered read data.
// One request at a time: req_ready is high only while the sequencer is idle.
// Synchronous reset clears the thread count, presence flags and response valid;
// slot and id maps are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Lottery ticket sum heap - top level
// Max-heap of threads by ticket count with per-slot descendant sums and an
// id-to-slot map, run by a sequencer around one shared arithmetic unit.
// ----------------------------------------------------------------------------
`include "lottery_ticket_sum_heap_defines.svh"

module lottery_ticket_sum_heap #(
   parameter int MAX_THREADS = lths_pkg::MAX_THREADS_DEF,
   parameter int TICKET_BITS = lths_pkg::TICKET_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_op,
   input  logic [lths_pkg::ID_W-1:0]        req_thread_id,
   input  logic [lths_pkg::TICKET_IN_W-1:0] req_tickets,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [lths_pkg::STATUS_W-1:0]    rsp_status,
   output logic [lths_pkg::ID_W-1:0]        rsp_result_id,
   output logic [lths_pkg::TICKET_IN_W-1:0] rsp_result_tickets,
   output logic [lths_pkg::COUNT_OUT_W-1:0] rsp_entry_count,
   output logic [lths_pkg::SUM_W-1:0]       rsp_total_tickets
);
   import lths_pkg::*;

   localparam int SW     = $clog2(MAX_THREADS);
   localparam int CW     = $clog2(MAX_THREADS + 1);
   localparam int TW     = TICKET_BITS;
   localparam int WORD_W = ID_W + TW + SUM_W;

   typedef enum logic [4:0] {
      S_IDLE, S_RM_MAP, S_RM_POS, S_RM_LAST, S_ANC, S_ANC_WR, S_RM_SUM, S_RM_PAR,
      S_UP, S_UP_CMP, S_DOWN, S_DN_L, S_DN_R, S_DN_CMP, S_FINAL, S_TOT, S_TOT_RD,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      PASS_INS, PASS_RM1, PASS_RM2
   } pass_type;

   logic [WORD_W-1:0] slot_mem [MAX_THREADS];
   logic [SW-1:0]     map_mem  [ID_COUNT];

   logic              slot_we;
   logic [SW-1:0]     slot_waddr, slot_raddr;
   logic [WORD_W-1:0] slot_wdata, slot_rdata_ff;
   logic              map_we;
   logic [ID_W-1:0]   map_waddr, map_raddr;
   logic [SW-1:0]     map_wdata, map_rdata_ff;

   logic [ID_W-1:0]   rd_id;
   logic [TW-1:0]     rd_tk;
   logic [SUM_W-1:0]  rd_sum;

   state_type         state_ff, state_in;
   pass_type          pass_ff, pass_in;
   logic [CW-1:0]     size_ff, size_in;
   logic [ID_COUNT-1:0] present_ff, present_in;
   logic [ID_W-1:0]   id_ff, id_in;
   status_type        status_ff, status_in;
   logic [TW-1:0]     rtk_ff, rtk_in;
   logic [ID_W-1:0]   cur_id_ff, cur_id_in;
   logic [TW-1:0]     cur_tk_ff, cur_tk_in;
   logic [SUM_W-1:0]  cur_sum_ff, cur_sum_in;
   logic [SW-1:0]     pos_ff, pos_in;
   logic [SW-1:0]     last_ff, last_in;
   logic [SW-1:0]     a_ff, a_in;
   logic [SUM_W-1:0]  delta_ff, delta_in;
   logic [ID_W-1:0]   ch_id_ff, ch_id_in;
   logic [TW-1:0]     ch_tk_ff, ch_tk_in;
   logic [SUM_W-1:0]  ch_sum_ff, ch_sum_in;
   logic [SW-1:0]     ch_pos_ff, ch_pos_in;
   logic [SUM_W-1:0]  total_ff, total_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]        rsp_id_ff, rsp_id_in;
   logic [TICKET_IN_W-1:0] rsp_tk_ff, rsp_tk_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [SUM_W-1:0]       rsp_total_ff, rsp_total_in;

   logic [SUM_W-1:0] alu_a, alu_b, alu_c, alu_sum;
   logic [TW-1:0]    alu_x, alu_y;
   logic             alu_gt;

   logic [TW-1:0]    tk_in;
   logic [SW-1:0]    par_pos, par_a;
   logic [SW+1:0]    l_w, r_w, size_x;
   logic [31:0]      rtk_wide, size_wide;

   lths_alu #(
      .TICKET_BITS(TICKET_BITS)
   ) u_alu (
      .add_a(alu_a),
      .add_b(alu_b),
      .add_c(alu_c),
      .cmp_x(alu_x),
      .cmp_y(alu_y),
      .sum  (alu_sum),
      .gt   (alu_gt)
   );

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      slot_rdata_ff <= slot_mem[slot_raddr];
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      map_rdata_ff <= map_mem[map_raddr];
   end

   assign rd_sum = slot_rdata_ff[SUM_W-1:0];
   assign rd_tk  = slot_rdata_ff[SUM_W +: TW];
   assign rd_id  = slot_rdata_ff[SUM_W+TW +: ID_W];

   assign tk_in   = TW'(32'(req_tickets));
   assign par_pos = (pos_ff - SW'(1)) >> 1;
   assign par_a   = (a_ff - SW'(1)) >> 1;
   assign l_w     = {1'b0, pos_ff, 1'b1};
   assign r_w     = l_w + (SW+2)'(1);
   assign size_x  = (SW+2)'(size_ff);

   assign rtk_wide  = 32'(rtk_ff);
   assign size_wide = 32'(size_ff);

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_id      = rsp_id_ff;
   assign rsp_result_tickets = rsp_tk_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_total_tickets  = rsp_total_ff;

   always_comb begin
      state_in   = state_ff;
      pass_in    = pass_ff;
      size_in    = size_ff;
      present_in = present_ff;
      id_in      = id_ff;
      status_in  = status_ff;
      rtk_in     = rtk_ff;
      cur_id_in  = cur_id_ff;
      cur_tk_in  = cur_tk_ff;
      cur_sum_in = cur_sum_ff;
      pos_in     = pos_ff;
      last_in    = last_ff;
      a_in       = a_ff;
      delta_in   = delta_ff;
      ch_id_in   = ch_id_ff;
      ch_tk_in   = ch_tk_ff;
      ch_sum_in  = ch_sum_ff;
      ch_pos_in  = ch_pos_ff;
      total_in   = total_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_tk_in     = rsp_tk_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_total_in  = rsp_total_ff;

      slot_we    = 1'b0;
      slot_waddr = pos_ff;
      slot_wdata = {cur_id_ff, cur_tk_ff, cur_sum_ff};
      slot_raddr = '0;
      map_we     = 1'b0;
      map_waddr  = cur_id_ff;
      map_wdata  = pos_ff;
      map_raddr  = req_thread_id;

      alu_a = '0;
      alu_b = '0;
      alu_c = '0;
      alu_x = cur_tk_ff;
      alu_y = rd_tk;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               id_in = req_thread_id;
               if (op_type'(req_op) == OP_INSERT) begin
                  if (size_ff >= CW'(MAX_THREADS) || present_ff[req_thread_id]) begin
                     status_in = STATUS_FULL;
                     rtk_in    = '0;
                     state_in  = S_TOT;
                  end else begin
                     status_in  = STATUS_OK;
                     rtk_in     = tk_in;
                     cur_id_in  = req_thread_id;
                     cur_tk_in  = tk_in;
                     cur_sum_in = '0;
                     pos_in     = SW'(size_ff);
                     a_in       = SW'(size_ff);
                     delta_in   = SUM_W'(tk_in);
                     pass_in    = PASS_INS;
                     present_in[req_thread_id] = 1'b1;
                     size_in    = size_ff + CW'(1);
                     state_in   = S_ANC;
                  end
               end else begin
                  if (!present_ff[req_thread_id] || size_ff == '0) begin
                     status_in = STATUS_ABSENT;
                     rtk_in    = '0;
                     state_in  = S_TOT;
                  end else begin
                     status_in = STATUS_OK;
                     present_in[req_thread_id] = 1'b0;
                     size_in   = size_ff - CW'(1);
                     last_in   = SW'(size_ff - CW'(1));
                     state_in  = S_RM_MAP;
                  end
               end
            end
         end
         S_RM_MAP: begin
            pos_in     = map_rdata_ff;
            slot_raddr = map_rdata_ff;
            state_in   = S_RM_POS;
         end
         S_RM_POS: begin
            rtk_in     = rd_tk;
            slot_raddr = last_ff;
            state_in   = S_RM_LAST;
         end
         S_RM_LAST: begin
            cur_id_in = rd_id;
            cur_tk_in = rd_tk;
            alu_c     = SUM_W'(rd_tk);
            delta_in  = alu_sum;
            a_in      = last_ff;
            pass_in   = PASS_RM1;
            state_in  = S_ANC;
         end
         S_ANC: begin
            if (a_ff == '0) begin
               unique case (pass_ff)
                  PASS_INS: begin
                     state_in = S_UP;
                  end
                  PASS_RM1: begin
                     if (pos_ff == last_ff) begin
                        state_in = S_TOT;
                     end else begin
                        alu_b    = SUM_W'(cur_tk_ff);
                        alu_c    = SUM_W'(rtk_ff);
                        delta_in = alu_sum;
                        a_in     = pos_ff;
                        pass_in  = PASS_RM2;
                     end
                  end
                  default: begin
                     slot_raddr = pos_ff;
                     state_in   = S_RM_SUM;
                  end
               endcase
            end else begin
               a_in       = par_a;
               slot_raddr = par_a;
               state_in   = S_ANC_WR;
            end
         end
         S_ANC_WR: begin
            alu_a      = rd_sum;
            alu_b      = delta_ff;
            slot_we    = 1'b1;
            slot_waddr = a_ff;
            slot_wdata = {rd_id, rd_tk, alu_sum};
            state_in   = S_ANC;
         end
         S_RM_SUM: begin
            cur_sum_in = rd_sum;
            if (pos_ff != '0) begin
               slot_raddr = par_pos;
               state_in   = S_RM_PAR;
            end else begin
               state_in = S_DOWN;
            end
         end
         S_RM_PAR: begin
            state_in = alu_gt ? S_UP : S_DOWN;
         end
         S_UP: begin
            if (pos_ff == '0) begin
               state_in = S_FINAL;
            end else begin
               slot_raddr = par_pos;
               state_in   = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            alu_a = rd_sum;
            alu_b = SUM_W'(rd_tk);
            alu_c = SUM_W'(cur_tk_ff);
            if (alu_gt) begin
               slot_we    = 1'b1;
               slot_wdata = {rd_id, rd_tk, cur_sum_ff};
               map_we     = 1'b1;
               map_waddr  = rd_id;
               cur_sum_in = alu_sum;
               pos_in     = par_pos;
               state_in   = S_UP;
            end else begin
               state_in = S_FINAL;
            end
         end
         S_DOWN: begin
            if (l_w >= size_x) begin
               state_in = S_FINAL;
            end else begin
               slot_raddr = l_w[SW-1:0];
               state_in   = S_DN_L;
            end
         end
         S_DN_L: begin
            ch_id_in  = rd_id;
            ch_tk_in  = rd_tk;
            ch_sum_in = rd_sum;
            ch_pos_in = l_w[SW-1:0];
            if (r_w < size_x) begin
               slot_raddr = r_w[SW-1:0];
               state_in   = S_DN_R;
            end else begin
               state_in = S_DN_CMP;
            end
         end
         S_DN_R: begin
            alu_x = rd_tk;
            alu_y = ch_tk_ff;
            if (alu_gt) begin
               ch_id_in  = rd_id;
               ch_tk_in  = rd_tk;
               ch_sum_in = rd_sum;
               ch_pos_in = r_w[SW-1:0];
            end
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            alu_x = ch_tk_ff;
            alu_y = cur_tk_ff;
            alu_a = cur_sum_ff;
            alu_b = SUM_W'(cur_tk_ff);
            alu_c = SUM_W'(ch_tk_ff);
            if (alu_gt) begin
               slot_we    = 1'b1;
               slot_wdata = {ch_id_ff, ch_tk_ff, alu_sum};
               map_we     = 1'b1;
               map_waddr  = ch_id_ff;
               cur_sum_in = ch_sum_ff;
               pos_in     = ch_pos_ff;
               state_in   = S_DOWN;
            end else begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            slot_we  = 1'b1;
            map_we   = 1'b1;
            state_in = S_TOT;
         end
         S_TOT: begin
            slot_raddr = '0;
            state_in   = S_TOT_RD;
         end
         S_TOT_RD: begin
            alu_a    = rd_sum;
            alu_b    = SUM_W'(rd_tk);
            total_in = (size_ff == '0) ? '0 : alu_sum;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_id_in     = id_ff;
               rsp_tk_in     = rtk_wide[TICKET_IN_W-1:0];
               rsp_count_in  = size_wide[COUNT_OUT_W-1:0];
               rsp_total_in  = total_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         size_ff      <= '0;
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         present_ff   <= present_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pass_ff       <= pass_in;
      id_ff         <= id_in;
      status_ff     <= status_in;
      rtk_ff        <= rtk_in;
      cur_id_ff     <= cur_id_in;
      cur_tk_ff     <= cur_tk_in;
      cur_sum_ff    <= cur_sum_in;
      pos_ff        <= pos_in;
      last_ff       <= last_in;
      a_ff          <= a_in;
      delta_ff      <= delta_in;
      ch_id_ff      <= ch_id_in;
      ch_tk_ff      <= ch_tk_in;
      ch_sum_ff     <= ch_sum_in;
      ch_pos_ff     <= ch_pos_in;
      total_ff      <= total_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_tk_ff     <= rsp_tk_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_total_ff  <= rsp_total_in;
   end

   `LTHS_ASSERT_NXT(a_busy_after_request, req_valid && req_ready, !req_ready, "request not held busy")
   `LTHS_ASSERT_IMP(a_count_matches_map, 1'b1, 32'($countones(present_ff)) == 32'(size_ff), "count mismatch")
   `LTHS_ASSERT_IMP(a_pos_in_heap, state_ff == S_UP || state_ff == S_DOWN, 32'(pos_ff) < 32'(size_ff), "sift outside heap")
   `LTHS_ASSERT_NXT(a_done_delivers, state_ff == S_DONE && (!rsp_valid_ff || rsp_ready), rsp_valid && req_ready, "response not issued")

endmodule
